### sv/ntlv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the named-field TLV byte parser.
// No dependencies; imported by ntlv_step, named_field_tlv_parser and the bench.
package ntlv_pkg;

   // Phase codes of the parse state and role codes of a response
   localparam logic [2:0] PH_NLEN = 3'd0;
   localparam logic [2:0] PH_NAME = 3'd1;
   localparam logic [2:0] PH_TYPE = 3'd2;
   localparam logic [2:0] PH_LLO  = 3'd3;
   localparam logic [2:0] PH_LHI  = 3'd4;
   localparam logic [2:0] PH_DATA = 3'd5;

   localparam logic [2:0] ROLE_NLEN    = 3'd0;
   localparam logic [2:0] ROLE_NAME    = 3'd1;
   localparam logic [2:0] ROLE_TYPE    = 3'd2;
   localparam logic [2:0] ROLE_LLO     = 3'd3;
   localparam logic [2:0] ROLE_LHI     = 3'd4;
   localparam logic [2:0] ROLE_DATA    = 3'd5;
   localparam logic [2:0] ROLE_IGNORED = 3'd6;

   localparam int NAME_KEEP_DEF = 16;
   localparam int DATA_KEEP_DEF = 64;

   localparam int LEN_HI_SHIFT = 8;

   typedef struct packed {
      logic [2:0]  phase;
      logic [15:0] remaining;
      logic [15:0] section_offset;
      logic [7:0]  current_type;
      logic [15:0] current_length;
      logic        error_flag;
   } state_type;

   typedef struct packed {
      logic [2:0]  role;
      logic [7:0]  byte_value;
      logic [15:0] offset;
      logic        kept;
      logic [7:0]  field_type;
      logic [15:0] data_length;
      logic        field_done;
      logic        failed;
      logic        buffer_done;
   } rsp_type;

   localparam state_type STATE_CLEAR = '{
      phase:          PH_NLEN,
      remaining:      16'd0,
      section_offset: 16'd0,
      current_type:   8'd0,
      current_length: 16'd0,
      error_flag:     1'b0
   };

endpackage

### sv/named_field_tlv_parser.sv
`timescale 1ns / 1ps
// Named-field TLV parser: one byte per request, one labelled response per byte.
// Pipeline: input reg then result reg, with the parse step between them.
// Throughput: 1 request per cycle while rsp_stall does not hold a full result reg;
// the parse step is a single pass of small logic.
// Reset (synchronous, active high): both stages empty, parse state at name length.
// Depends on ntlv_pkg and ntlv_step.
module named_field_tlv_parser #(
   parameter int NAME_KEEP = ntlv_pkg::NAME_KEEP_DEF,
   parameter int DATA_KEEP = ntlv_pkg::DATA_KEEP_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_role,
   output logic [7:0]  rsp_byte_value,
   output logic [15:0] rsp_offset,
   output logic        rsp_kept,
   output logic [7:0]  rsp_field_type,
   output logic [15:0] rsp_data_length,
   output logic        rsp_field_done,
   output logic        rsp_failed,
   output logic        rsp_buffer_done
);
   import ntlv_pkg::*;

   // input register stage
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_first_ff, s1_last_ff;

   // parse state, advanced once per byte leaving stage 1
   state_type   state_ff, state_in;

   // result register stage
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, step_rsp;

   logic        s2_free;   // result register can load this cycle
   logic        s1_move;   // stage 1 byte is parsed and loaded into result
   logic        req_take;

   assign s2_free   = !out_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && s2_free;
   assign req_stall = s1_valid_ff && !s2_free;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s2_free);
   assign out_valid_in = s1_move || (out_valid_ff && rsp_stall);

   ntlv_step #(
      .NAME_KEEP (NAME_KEEP),
      .DATA_KEEP (DATA_KEEP)
   ) u_step (
      .st_cur     (state_ff),
      .in_byte    (s1_byte_ff),
      .first_byte (s1_first_ff),
      .last_byte  (s1_last_ff),
      .st_nxt     (state_in),
      .rsp        (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_CLEAR;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_move) state_ff <= state_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff  <= req_in_byte;
         s1_first_ff <= req_first_byte;
         s1_last_ff  <= req_last_byte;
      end
      if (s1_move) out_ff <= step_rsp;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_role        = out_ff.role;
   assign rsp_byte_value  = out_ff.byte_value;
   assign rsp_offset      = out_ff.offset;
   assign rsp_kept        = out_ff.kept;
   assign rsp_field_type  = out_ff.field_type;
   assign rsp_data_length = out_ff.data_length;
   assign rsp_field_done  = out_ff.field_done;
   assign rsp_failed      = out_ff.failed;
   assign rsp_buffer_done = out_ff.buffer_done;

   // a clean buffer end and an error cannot be reported together
   a_done_xor_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_buffer_done && rsp_failed))
      else $error("buffer_done with failed");

   // ignored bytes only appear while the error is set
   a_ignored_failed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_role == ROLE_IGNORED) |-> rsp_failed)
      else $error("ignored byte without failed");

   // error sticks until a first byte of a new buffer is parsed
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (state_ff.error_flag && !(s1_move && s1_first_ff)) |=> state_ff.error_flag)
      else $error("error flag dropped");

   // header bytes carry offset zero
   a_hdr_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_role != ROLE_NAME && rsp_role != ROLE_DATA)
         |-> (rsp_offset == 16'd0))
      else $error("nonzero offset on header byte");

endmodule

### sv/ntlv_step.sv
`timescale 1ns / 1ps
// Per-byte parse step: current state plus one byte gives next state and response.
// Depends on ntlv_pkg.
module ntlv_step #(
   parameter int NAME_KEEP = ntlv_pkg::NAME_KEEP_DEF,
   parameter int DATA_KEEP = ntlv_pkg::DATA_KEEP_DEF
) (
   input  ntlv_pkg::state_type st_cur,
   input  logic [7:0]          in_byte,
   input  logic                first_byte,
   input  logic                last_byte,
   output ntlv_pkg::state_type st_nxt,
   output ntlv_pkg::rsp_type   rsp
);
   import ntlv_pkg::*;

   state_type   st;
   state_type   nx;
   logic [15:0] dec;

   always_comb begin
      st  = first_byte ? STATE_CLEAR : st_cur;
      nx  = st;
      dec = st.remaining - 16'd1;

      rsp             = '0;
      rsp.byte_value  = in_byte;
      rsp.kept        = 1'b1;

      if (st.error_flag) begin
         // sticky error: byte is dropped, state holds
         rsp.role   = ROLE_IGNORED;
         rsp.kept   = 1'b0;
         rsp.failed = 1'b1;
      end else begin
         unique case (st.phase)
            PH_NAME: begin
               rsp.role          = ROLE_NAME;
               rsp.offset        = st.section_offset;
               rsp.kept          = st.section_offset < 16'(NAME_KEEP);
               nx.section_offset = st.section_offset + 16'd1;
               nx.remaining      = dec;
               if (dec == 16'd0) nx.phase = PH_TYPE;
            end
            PH_TYPE: begin
               rsp.role        = ROLE_TYPE;
               rsp.field_type  = in_byte;
               nx.current_type = in_byte;
               nx.phase        = PH_LLO;
            end
            PH_LLO: begin
               rsp.role          = ROLE_LLO;
               rsp.field_type    = st.current_type;
               nx.current_length = {8'd0, in_byte};
               nx.phase          = PH_LHI;
            end
            PH_LHI: begin
               rsp.role          = ROLE_LHI;
               rsp.field_type    = st.current_type;
               nx.current_length = (16'(in_byte) << LEN_HI_SHIFT)
                                   | {8'd0, st.current_length[7:0]};
               rsp.data_length   = nx.current_length;
               nx.remaining      = nx.current_length;
               nx.section_offset = 16'd0;
               if (nx.current_length == 16'd0) begin
                  rsp.field_done = 1'b1;
                  nx.phase       = PH_NLEN;
               end else begin
                  nx.phase = PH_DATA;
               end
            end
            PH_DATA: begin
               rsp.role          = ROLE_DATA;
               rsp.field_type    = st.current_type;
               rsp.data_length   = st.current_length;
               rsp.offset        = st.section_offset;
               rsp.kept          = st.section_offset < 16'(DATA_KEEP);
               nx.section_offset = st.section_offset + 16'd1;
               nx.remaining      = dec;
               if (dec == 16'd0) begin
                  rsp.field_done = 1'b1;
                  nx.phase       = PH_NLEN;
               end
            end
            default: begin
               // name length byte; unused phase codes land here too
               rsp.role          = ROLE_NLEN;
               nx.remaining      = {8'd0, in_byte};
               nx.section_offset = 16'd0;
               nx.current_type   = 8'd0;
               nx.current_length = 16'd0;
               nx.phase          = (in_byte == 8'd0) ? PH_TYPE : PH_NAME;
            end
         endcase

         if (last_byte) begin
            if (nx.phase == PH_NLEN) rsp.buffer_done = 1'b1;
            else nx.error_flag = 1'b1;
         end
         rsp.failed = nx.error_flag;
      end
      st_nxt = nx;
   end

endmodule

### tb/named_field_tlv_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for named_field_tlv_parser: a directed table, then random TLV buffers.
// Depends on ntlv_pkg and the parser RTL; responses are checked against a local predictor or hand-written labels.
module named_field_tlv_parser_tb;
   import ntlv_pkg::*;

   localparam int NAME_KEEP      = NAME_KEEP_DEF;
   localparam int DATA_KEEP      = DATA_KEEP_DEF;
   localparam int ITEM_TARGET    = 1050;  // minimum number of requests sent over the whole run
   localparam int HOLD_AT        = 300;   // response count at which the long back-pressure starts
   localparam int HOLD_CYCLES    = 200;
   localparam int CALM_LO        = 500;   // window with no idling on either side
   localparam int CALM_HI        = 700;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int MAX_REPORTS    = 10;

   // one directed row: the request, plus an optional hand-written response
   typedef struct packed {
      logic [7:0] in_byte;
      logic       first;
      logic       last;
      logic       has_label;
      rsp_type    label;
   } dir_row_type;

   logic        clock;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte    = 8'h00;
   logic        req_first_byte = 1'b0;
   logic        req_last_byte  = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [2:0]  rsp_role;
   logic [7:0]  rsp_byte_value;
   logic [15:0] rsp_offset;
   logic        rsp_kept;
   logic [7:0]  rsp_field_type;
   logic [15:0] rsp_data_length;
   logic        rsp_field_done;
   logic        rsp_failed;
   logic        rsp_buffer_done;

   state_type   parse_state = STATE_CLEAR;  // predictor's copy of the parse state
   rsp_type     labels_due[$];              // predicted responses, oldest first
   dir_row_type directed_rows[$];
   int          sent_count    = 0;
   int          rsp_count     = 0;
   int          fail_count    = 0;
   int          hold_left     = 0;
   bit          hold_done     = 1'b0;
   int          quiet_cycles  = 0;

   named_field_tlv_parser u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_first_byte  (req_first_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_role        (rsp_role),
      .rsp_byte_value  (rsp_byte_value),
      .rsp_offset      (rsp_offset),
      .rsp_kept        (rsp_kept),
      .rsp_field_type  (rsp_field_type),
      .rsp_data_length (rsp_data_length),
      .rsp_field_done  (rsp_field_done),
      .rsp_failed      (rsp_failed),
      .rsp_buffer_done (rsp_buffer_done)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Predictor: labels one byte and advances the parse state.
   function automatic rsp_type label_byte(input logic [7:0] b, input logic first,
                                          input logic last);
      rsp_type r;
      if (first) parse_state = STATE_CLEAR;
      r            = '0;
      r.byte_value = b;
      r.kept       = 1'b1;
      // after a broken buffer everything is ignored until the next first byte
      if (parse_state.error_flag) begin
         r.role   = ROLE_IGNORED;
         r.kept   = 1'b0;
         r.failed = 1'b1;
         return r;
      end
      case (parse_state.phase)
         PH_NAME: begin
            r.role   = ROLE_NAME;
            r.offset = parse_state.section_offset;
            r.kept   = (parse_state.section_offset < NAME_KEEP);
            parse_state.section_offset = parse_state.section_offset + 16'd1;
            parse_state.remaining      = parse_state.remaining - 16'd1;
            if (parse_state.remaining == 16'd0) parse_state.phase = PH_TYPE;
         end
         PH_TYPE: begin
            r.role                   = ROLE_TYPE;
            r.field_type             = b;
            parse_state.current_type = b;
            parse_state.phase        = PH_LLO;
         end
         PH_LLO: begin
            r.role                     = ROLE_LLO;
            r.field_type               = parse_state.current_type;
            parse_state.current_length = {8'h00, b};
            parse_state.phase          = PH_LHI;
         end
         PH_LHI: begin
            // little-endian: high byte lands on top of the stored low byte
            r.role                     = ROLE_LHI;
            r.field_type               = parse_state.current_type;
            parse_state.current_length = {b, parse_state.current_length[7:0]};
            r.data_length              = parse_state.current_length;
            parse_state.remaining      = parse_state.current_length;
            parse_state.section_offset = 16'd0;
            if (parse_state.remaining == 16'd0) begin
               r.field_done      = 1'b1;  // empty data section
               parse_state.phase = PH_NLEN;
            end else begin
               parse_state.phase = PH_DATA;
            end
         end
         PH_DATA: begin
            r.role        = ROLE_DATA;
            r.field_type  = parse_state.current_type;
            r.data_length = parse_state.current_length;
            r.offset      = parse_state.section_offset;
            r.kept        = (parse_state.section_offset < DATA_KEEP);
            parse_state.section_offset = parse_state.section_offset + 16'd1;
            parse_state.remaining      = parse_state.remaining - 16'd1;
            if (parse_state.remaining == 16'd0) begin
               r.field_done      = 1'b1;
               parse_state.phase = PH_NLEN;
            end
         end
         default: begin
            // name length byte; a zero length skips straight to the type
            r.role                     = ROLE_NLEN;
            parse_state.remaining      = {8'h00, b};
            parse_state.section_offset = 16'd0;
            parse_state.current_type   = 8'h00;
            parse_state.current_length = 16'd0;
            parse_state.phase          = (b == 8'h00) ? PH_TYPE : PH_NAME;
         end
      endcase
      if (last) begin
         if (parse_state.phase == PH_NLEN) r.buffer_done = 1'b1;
         else parse_state.error_flag = 1'b1;
      end
      r.failed = parse_state.error_flag;
      return r;
   endfunction

   function automatic rsp_type rsp_of(input logic [2:0] role, input logic [7:0] b,
                                      input logic [15:0] offset, input logic kept,
                                      input logic [7:0] ftype, input logic [15:0] dlen,
                                      input logic done, input logic failed,
                                      input logic bdone);
      rsp_of = '{role, b, offset, kept, ftype, dlen, done, failed, bdone};
   endfunction

   task automatic add_row(input logic [7:0] b, input logic first, input logic last,
                          input logic has_label, input rsp_type label);
      directed_rows.push_back('{b, first, last, has_label, label});
   endtask

   // Offers one request, holds it until accepted, then records the expected response.
   // The predictor always runs so its state tracks the block, even on hand-written rows.
   task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                            input logic has_label, input rsp_type label);
      rsp_type predicted;
      bit      calm;
      calm = (sent_count >= CALM_LO) && (sent_count < CALM_HI);
      while (!calm && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_in_byte    <= b;
      req_first_byte <= first;
      req_last_byte  <= last;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = label_byte(b, first, last);
      labels_due.push_back(has_label ? label : predicted);
      sent_count++;
   endtask

   // One random buffer: mostly well-formed fields with random content, some cut short,
   // some opened without a first byte, plus occasional noise.
   task automatic random_buffer();
      logic [7:0] enc[$];
      int         nfields;
      int         nlen;
      int         dlen;
      int         pick;
      int         cut;
      logic       opens;
      if ($urandom_range(0, 9) == 0) begin
         // noise: random bytes with random framing bits
         repeat ($urandom_range(1, 6))
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b0, '0);
         return;
      end
      nfields = $urandom_range(1, 3);
      for (int k = 0; k < nfields; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) nlen = $urandom_range(0, 4);
         else if (pick < 95) nlen = $urandom_range(5, 24);  // crosses the kept name prefix
         else nlen = $urandom_range(200, 255);
         pick = $urandom_range(0, 99);
         if (pick < 55) dlen = $urandom_range(0, 6);
         else if (pick < 93) dlen = $urandom_range(7, 80);  // crosses the kept data prefix
         else dlen = $urandom_range(256, 300);              // nonzero length high byte
         enc.push_back(nlen[7:0]);
         repeat (nlen) enc.push_back(8'($urandom_range(0, 255)));
         enc.push_back(8'($urandom_range(0, 255)));
         enc.push_back(dlen[7:0]);
         enc.push_back(dlen[15:8]);
         repeat (dlen) enc.push_back(8'($urandom_range(0, 255)));
      end
      // truncated buffer: may end inside a field or between fields
      cut = enc.size();
      if (enc.size() > 1 && $urandom_range(0, 99) < 15) cut = $urandom_range(1, enc.size() - 1);
      opens = ($urandom_range(0, 9) != 0);
      for (int i = 0; i < cut; i++) begin
         if (sent_count >= ITEM_TARGET) break;  // run budget spent
         send_byte(enc[i], (i == 0) && opens, i == cut - 1, 1'b0, '0);
      end
      // stray bytes after a truncated buffer, which the block should ignore if the cut left it broken
      if (cut != enc.size() && $urandom_range(0, 1) == 1)
         repeat ($urandom_range(1, 3))
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                      1'b0, '0);
   endtask

   // Response side: checks every accepted response, stalls at random, and once holds off
   // for a long stretch so the pipeline fills and pushes back on requests.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      bit      calm;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            got = '{rsp_role, rsp_byte_value, rsp_offset, rsp_kept, rsp_field_type,
                    rsp_data_length, rsp_field_done, rsp_failed, rsp_buffer_done};
            rsp_count++;
            if (labels_due.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("unexpected response: role=%0d byte=%h", got.role, got.byte_value);
            end else begin
               want = labels_due.pop_front();
               if (got.role !== want.role || got.byte_value !== want.byte_value ||
                   got.offset !== want.offset || got.kept !== want.kept ||
                   got.field_type !== want.field_type ||
                   got.data_length !== want.data_length ||
                   got.field_done !== want.field_done || got.failed !== want.failed ||
                   got.buffer_done !== want.buffer_done) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS) begin
                     $display("mismatch at response %0d", rsp_count);
                     $display("  want role=%0d byte=%h off=%0d kept=%b type=%h len=%0d done=%b fail=%b bdone=%b",
                              want.role, want.byte_value, want.offset, want.kept,
                              want.field_type, want.data_length, want.field_done,
                              want.failed, want.buffer_done);
                     $display("  got  role=%0d byte=%h off=%0d kept=%b type=%h len=%0d done=%b fail=%b bdone=%b",
                              got.role, got.byte_value, got.offset, got.kept,
                              got.field_type, got.data_length, got.field_done,
                              got.failed, got.buffer_done);
                  end
               end
            end
         end
         calm = (rsp_count >= CALM_LO) && (rsp_count < CALM_HI);
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (rsp_count >= HOLD_AT && !hold_done) begin
            rsp_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 20);
         end
      end
   end

   // Watchdog: too long without any handshake on either channel means a hang.
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("named_field_tlv_parser regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // clean field with empty name and empty data, closing the buffer
      add_row(8'h00, 1'b1, 1'b0, 1'b1,
              rsp_of(ROLE_NLEN, 8'h00, 16'd0, 1'b1, 8'h00, 16'd0, 1'b0, 1'b0, 1'b0));
      add_row(8'hFF, 1'b0, 1'b0, 1'b1,
              rsp_of(ROLE_TYPE, 8'hFF, 16'd0, 1'b1, 8'hFF, 16'd0, 1'b0, 1'b0, 1'b0));
      add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b1, 1'b1,
              rsp_of(ROLE_LHI, 8'h00, 16'd0, 1'b1, 8'hFF, 16'd0, 1'b1, 1'b0, 1'b1));
      // further field after a clean end, no first byte
      add_row(8'h02, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h41, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h42, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h01, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b0, 1'b1, 1'b0, '0);
      // buffer ends right after a name length: sticky error
      add_row(8'h03, 1'b1, 1'b1, 1'b1,
              rsp_of(ROLE_NLEN, 8'h03, 16'd0, 1'b1, 8'h00, 16'd0, 1'b0, 1'b1, 1'b0));
      add_row(8'hAA, 1'b0, 1'b0, 1'b1,
              rsp_of(ROLE_IGNORED, 8'hAA, 16'd0, 1'b0, 8'h00, 16'd0, 1'b0, 1'b1, 1'b0));
      add_row(8'h55, 1'b0, 1'b1, 1'b1,
              rsp_of(ROLE_IGNORED, 8'h55, 16'd0, 1'b0, 8'h00, 16'd0, 1'b0, 1'b1, 1'b0));
      // first byte clears the error; maximum length, buffer cut at the length high byte
      add_row(8'h01, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h80, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h7E, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b0, 1'b1, 1'b1,
              rsp_of(ROLE_LHI, 8'hFF, 16'd0, 1'b1, 8'h7E, 16'hFFFF, 1'b0, 1'b1, 1'b0));
      // one-byte buffer holding an empty name length
      add_row(8'h00, 1'b1, 1'b1, 1'b1,
              rsp_of(ROLE_NLEN, 8'h00, 16'd0, 1'b1, 8'h00, 16'd0, 1'b0, 1'b1, 1'b0));

      foreach (directed_rows[i])
         send_byte(directed_rows[i].in_byte, directed_rows[i].first, directed_rows[i].last,
                   directed_rows[i].has_label, directed_rows[i].label);

      while (sent_count < ITEM_TARGET) random_buffer();
      req_valid <= 1'b0;

      // drain; the watchdog covers a response that never comes
      while (labels_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && labels_due.size() == 0)
         $display("named_field_tlv_parser regression: pass");
      else
         $display("named_field_tlv_parser regression: fail");
      $finish;
   end

endmodule
